/* hdl/bhm_pkg.sv */
package bhm_pkg;

  localparam logic [1:0] FUNC_RECORD = 2'd0;
  localparam logic [1:0] FUNC_MEDIAN = 2'd1;
  localparam logic [1:0] FUNC_COUNT  = 2'd2;

  typedef enum logic [1:0] {
    OP_RECORD = 2'd0,
    OP_MEDIAN = 2'd1,
    OP_COUNT  = 2'd2,
    OP_EMPTY  = 2'd3
  } op_t;

  localparam int GRP_W_MAX = 14;
  localparam int BIN_W_MAX = 12;

  typedef struct packed {
    op_t                   op;
    logic [GRP_W_MAX-1:0]  grp;
    logic [BIN_W_MAX-1:0]  bin;
  } cmd_t;

endpackage

/* hdl/binned_histogram_median_core.sv */
// Binned histogram median core.
// Input channel (in_valid/in_stall): func, sample_id, metric_id, gc_percent,
// value_hundredths. A transfer happens when in_valid is high and in_stall low.
// Output channel (out_valid/out_stall): median_sum, is_empty, window_count,
// one result for each median or count query; records and func 3 give none.
// The front classifies each item, clamps the bin and forms the group index,
// then pushes a command into a two-entry queue; it drops func 3 and records
// aimed outside the bank. The back pops commands and runs them against the
// bin memory (GROUPS*BINS words) and the totals memory.
// In the back, a record passes through S_TRD, S_TCHK, S_BRD and S_BWR; a count
// query reads the total and then waits in S_OUT for the output transfer; a median
// query runs the rank walk, which reads every bin of the group once, via S_WALK and S_WACC.
// After reset the back clears both memories, one bin word per cycle, through all
// SAMPLES*METRICS*GC_LEVELS*BINS bin words; the queue may fill during that time
// and then in_stall holds the input side.
// When the receiver stalls, the result holds on the ports and the back waits;
// the front keeps taking items until its queue is full.
module binned_histogram_median_core
  import bhm_pkg::*;
#(
  parameter int SAMPLES    = 2,
  parameter int METRICS    = 4,
  parameter int GC_LEVELS  = 101,
  parameter int BINS       = 256,
  parameter int COUNT_BITS = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [0:0]  sample_id,
  input  logic [1:0]  metric_id,
  input  logic [6:0]  gc_percent,
  input  logic signed [15:0] value_hundredths,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [8:0]  median_sum,
  output logic        is_empty,
  output logic [19:0] window_count
);

  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;
  logic busy_clear;

  // Front: classify and queue.
  bhm_front #(
    .SAMPLES(SAMPLES), .METRICS(METRICS), .GC_LEVELS(GC_LEVELS), .BINS(BINS)
  ) u_front (
    .clk, .rst, .in_valid, .in_stall, .func, .sample_id, .metric_id,
    .gc_percent, .value_hundredths, .q_valid, .q_pop, .q_cmd
  );

  // Back: update counts and walk ranks.
  bhm_back #(
    .SAMPLES(SAMPLES), .METRICS(METRICS), .GC_LEVELS(GC_LEVELS), .BINS(BINS),
    .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk, .rst, .q_valid, .q_pop, .q_cmd, .out_valid, .out_stall,
    .median_sum, .is_empty, .window_count, .busy_clear
  );

  // Never pop the queue while it is empty.
  a_pop_valid: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("pop from empty queue");

  // No result while the memories are still being cleared.
  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    busy_clear |-> !out_valid)
    else $error("result during clear");

  // An empty result carries a zero sum and a zero window count.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_empty) |-> (median_sum == 9'd0 && window_count == 20'd0))
    else $error("empty result with data");

endmodule

/* hdl/bhm_front.sv */
module bhm_front
  import bhm_pkg::*;
#(
  parameter int SAMPLES   = 2,
  parameter int METRICS   = 4,
  parameter int GC_LEVELS = 101,
  parameter int BINS      = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [0:0]  sample_id,
  input  logic [1:0]  metric_id,
  input  logic [6:0]  gc_percent,
  input  logic signed [15:0] value_hundredths,
  output logic        q_valid,
  input  logic        q_pop,
  output cmd_t        q_cmd
);

  localparam int DEPTH  = 2;

  cmd_t       fifo [DEPTH];
  logic [0:0] wr_ptr;
  logic [0:0] rd_ptr;
  logic [1:0] fill;
  cmd_t       cmd;
  logic       in_range;
  logic       cov_range;
  logic [31:0] grp_full;
  logic       keep;
  logic       push;

  assign in_stall = (fill == 2'(DEPTH));
  assign push     = in_valid && !in_stall && keep;

  always_comb begin
    in_range  = (32'(sample_id) < 32'(SAMPLES)) && (32'(metric_id) < 32'(METRICS)) &&
                (32'(gc_percent) < 32'(GC_LEVELS));
    cov_range = 32'(gc_percent) < 32'(GC_LEVELS);
    grp_full  = (32'(sample_id) * 32'(METRICS) + 32'(metric_id)) * 32'(GC_LEVELS) +
                32'(gc_percent);
    cmd.grp   = GRP_W_MAX'(grp_full);
    if (value_hundredths < 0) begin
      cmd.bin = '0;
    end else if (32'(value_hundredths) > 32'(BINS - 1)) begin
      cmd.bin = BIN_W_MAX'(BINS - 1);
    end else begin
      cmd.bin = BIN_W_MAX'(value_hundredths);
    end
    cmd.op = OP_EMPTY;
    keep   = 1'b1;
    unique case (func)
      FUNC_RECORD: begin
        // Drop records aimed outside the bank.
        cmd.op = OP_RECORD;
        keep   = in_range;
      end
      FUNC_MEDIAN: cmd.op = in_range ? OP_MEDIAN : OP_EMPTY;
      FUNC_COUNT: begin
        cmd.op  = cov_range ? OP_COUNT : OP_EMPTY;
        cmd.grp = GRP_W_MAX'(gc_percent);
      end
      default: begin
        cmd.op = OP_EMPTY;
        keep   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= cmd;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (q_pop) rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + 2'(push) - 2'(q_pop);
    end
  end

  assign q_valid = (fill != 2'd0);
  assign q_cmd   = fifo[rd_ptr];

endmodule

/* hdl/bhm_back.sv */
module bhm_back
  import bhm_pkg::*;
#(
  parameter int SAMPLES    = 2,
  parameter int METRICS    = 4,
  parameter int GC_LEVELS  = 101,
  parameter int BINS       = 256,
  parameter int COUNT_BITS = 20
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  output logic       q_pop,
  input  cmd_t       q_cmd,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [8:0] median_sum,
  output logic       is_empty,
  output logic [19:0] window_count,
  output logic       busy_clear
);

  localparam int GROUPS = SAMPLES * METRICS * GC_LEVELS;
  localparam int GW     = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int BW     = $clog2(BINS);
  localparam int MEMD   = GROUPS * BINS;
  localparam int AW     = $clog2(MEMD);
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_TRD, S_TCHK, S_BRD, S_BWR,
    S_WALK, S_WACC, S_DONE, S_OUT
  } state_t;

  state_t state;

  logic [COUNT_BITS-1:0] bin_mem [MEMD];
  logic [COUNT_BITS-1:0] tot_mem [GROUPS];
  logic [COUNT_BITS-1:0] bin_rd;
  logic [COUNT_BITS-1:0] tot_rd;
  logic [AW-1:0]         clr_addr;

  cmd_t                  cmd;
  logic [COUNT_BITS-1:0] total;
  logic [COUNT_BITS-1:0] rank_lo;
  logic [COUNT_BITS-1:0] rank_hi;
  logic [COUNT_BITS:0]   run;
  logic [COUNT_BITS:0]   run_next;
  logic [BW:0]           idx;
  logic [BW-1:0]         bin_a;
  logic [BW-1:0]         bin_b;
  logic                  have_a;
  logic                  have_b;

  logic                  bin_we;
  logic [AW-1:0]         bin_waddr;
  logic [COUNT_BITS-1:0] bin_wdata;
  logic [AW-1:0]         bin_raddr;
  logic                  tot_we;
  logic [GW-1:0]         tot_waddr;
  logic [COUNT_BITS-1:0] tot_wdata;

  function automatic logic [AW-1:0] addr_of(input logic [GW-1:0] g, input logic [BW-1:0] b);
    logic [63:0] t;
    t = 64'(g) * 64'(BINS) + 64'(b);
    return AW'(t);
  endfunction

  assign busy_clear = (state == S_CLEAR);
  assign q_pop      = (state == S_IDLE) && q_valid;
  assign run_next   = run + (COUNT_BITS+1)'(bin_rd);

  always_comb begin
    bin_raddr = addr_of(GW'(cmd.grp), BW'(cmd.bin));
    if (state == S_WALK || state == S_WACC) begin
      bin_raddr = addr_of(GW'(cmd.grp), BW'(idx));
    end
  end

  always_ff @(posedge clk) begin
    if (bin_we) bin_mem[bin_waddr] <= bin_wdata;
    bin_rd <= bin_mem[bin_raddr];
    if (tot_we) tot_mem[tot_waddr] <= tot_wdata;
    tot_rd <= tot_mem[GW'(cmd.grp)];
  end

  always_comb begin
    bin_we    = 1'b0;
    bin_waddr = addr_of(GW'(cmd.grp), BW'(cmd.bin));
    bin_wdata = bin_rd + 1'b1;
    tot_we    = 1'b0;
    tot_waddr = GW'(cmd.grp);
    tot_wdata = total + 1'b1;
    if (state == S_CLEAR) begin
      bin_we    = 1'b1;
      bin_waddr = clr_addr;
      bin_wdata = '0;
      tot_we    = (32'(clr_addr) < 32'(GROUPS));
      tot_waddr = GW'(clr_addr);
      tot_wdata = '0;
    end else if (state == S_BWR) begin
      bin_we = 1'b1;
      tot_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (32'(clr_addr) == MEMD - 1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (q_valid) begin
            cmd   <= q_cmd;
            state <= S_TRD;
          end
        end
        S_TRD: state <= S_TCHK;
        S_TCHK: begin
          total <= tot_rd;
          unique case (cmd.op)
            OP_RECORD: state <= (tot_rd == CMAX) ? S_IDLE : S_BRD;
            OP_MEDIAN: begin
              if (tot_rd == '0) begin
                median_sum   <= '0;
                is_empty     <= 1'b1;
                window_count <= '0;
                out_valid    <= 1'b1;
                state        <= S_OUT;
              end else begin
                if (tot_rd[0]) begin
                  rank_lo <= tot_rd >> 1;
                  rank_hi <= tot_rd >> 1;
                end else begin
                  rank_lo <= (tot_rd >> 1) - 1'b1;
                  rank_hi <= tot_rd >> 1;
                end
                run    <= '0;
                idx    <= '0;
                have_a <= 1'b0;
                have_b <= 1'b0;
                state  <= S_WALK;
              end
            end
            OP_COUNT: begin
              median_sum   <= '0;
              is_empty     <= (tot_rd == '0);
              window_count <= 20'(tot_rd);
              out_valid    <= 1'b1;
              state        <= S_OUT;
            end
            default: begin
              median_sum   <= '0;
              is_empty     <= 1'b1;
              window_count <= '0;
              out_valid    <= 1'b1;
              state        <= S_OUT;
            end
          endcase
        end
        S_BRD: state <= S_BWR;
        S_BWR: state <= S_IDLE;
        S_WALK: state <= S_WACC;
        S_WACC: begin
          run <= run_next;
          if (!have_a && run_next > (COUNT_BITS+1)'(rank_lo)) begin
            bin_a  <= BW'(idx);
            have_a <= 1'b1;
          end
          if (!have_b && run_next > (COUNT_BITS+1)'(rank_hi)) begin
            bin_b  <= BW'(idx);
            have_b <= 1'b1;
          end
          if (32'(idx) == BINS - 1) begin
            state <= S_DONE;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_WALK;
          end
        end
        S_DONE: begin
          median_sum   <= 9'((BW+1)'(have_a ? bin_a : BW'(BINS-1)) +
                             (BW+1)'(have_b ? bin_b : BW'(BINS-1)));
          is_empty     <= 1'b0;
          window_count <= '0;
          out_valid    <= 1'b1;
          state        <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* tb/tb_top.sv */
module tb_top
  import bhm_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_SAMPLES   = 2;
  localparam int N_METRICS   = 4;
  localparam int N_GC        = 101;
  localparam int N_BINS      = 256;
  localparam int N_GROUPS    = N_SAMPLES * N_METRICS * N_GC;
  localparam int unsigned CNT_MAX = (1 << 20) - 1;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int RAND_ITEMS  = 1525;
  // The limit covers the clearing pass after reset and a full walk for each median,
  // plus worst-case stalls on both sides, then margin on top of that.
  localparam longint CYCLE_LIMIT = 8_000_000;

  logic clk, rst;
  logic in_valid, in_stall;
  logic [1:0] func;
  logic [0:0] sample_id;
  logic [1:0] metric_id;
  logic [6:0] gc_percent;
  logic signed [15:0] value_hundredths;
  logic out_valid, out_stall;
  logic [8:0] median_sum;
  logic is_empty;
  logic [19:0] window_count;

  typedef struct {
    logic [8:0]  med;
    logic        empty;
    logic [19:0] win;
  } answer_t;

  typedef struct {
    logic [1:0]         fn;
    logic [0:0]         smp;
    logic [1:0]         met;
    logic [6:0]         gc;
    logic signed [15:0] val;
    bit                 typed;
    answer_t            ans;
  } stim_row_t;

  // Shadow copy of the histogram bank.
  int unsigned hist_bins[N_GROUPS*N_BINS];
  int unsigned hist_totals[N_GROUPS];
  answer_t     pending_answers[$];

  int  errors;
  bit  idle_enable;
  bit  hold_request;
  longint cycles;

  binned_histogram_median_core uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .sample_id(sample_id), .metric_id(metric_id),
    .gc_percent(gc_percent), .value_hundredths(value_hundredths),
    .out_valid(out_valid), .out_stall(out_stall),
    .median_sum(median_sum), .is_empty(is_empty), .window_count(window_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Group index, or -1 when any coordinate is out of range.
  function automatic int group_index(int s, int m, int g);
    if (s >= N_SAMPLES || m >= N_METRICS || g >= N_GC) return -1;
    return (s * N_METRICS + m) * N_GC + g;
  endfunction

  // First bin whose running count passes the given rank.
  function automatic int bin_for_rank(int grp, int unsigned rank);
    longint unsigned run;
    run = 0;
    for (int i = 0; i < N_BINS; i++) begin
      run += hist_bins[grp*N_BINS + i];
      if (run > rank) return i;
    end
    return N_BINS - 1;
  endfunction

  // Apply one transfer to the shadow bank; return 1 with the answer for queries.
  function automatic bit histogram_step(stim_row_t r, output answer_t a);
    int grp, bin, cg;
    int unsigned total, lo, hi;
    a = '{med: '0, empty: 1'b0, win: '0};
    grp = group_index(r.smp, r.met, r.gc);
    case (r.fn)
      FUNC_RECORD: begin
        if (grp < 0) return 0;
        bin = (r.val < 0) ? 0 : (r.val > N_BINS - 1) ? N_BINS - 1 : int'(r.val);
        if (hist_totals[grp] >= CNT_MAX) return 0;
        hist_bins[grp*N_BINS + bin]++;
        hist_totals[grp]++;
        return 0;
      end
      FUNC_MEDIAN: begin
        total = (grp < 0) ? 0 : hist_totals[grp];
        if (total == 0) begin
          a.empty = 1'b1;
          return 1;
        end
        if (total[0] == 1'b0) begin
          lo = total / 2 - 1;
          hi = lo + 1;
        end else begin
          lo = total / 2;
          hi = lo;
        end
        a.med = 9'(bin_for_rank(grp, lo) + bin_for_rank(grp, hi));
        return 1;
      end
      FUNC_COUNT: begin
        cg = group_index(0, 0, r.gc);
        total = (cg < 0) ? 0 : hist_totals[cg];
        a.empty = (total == 0);
        a.win = 20'(total);
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  // Offer one item and hold it until the transfer; queue the answer it causes.
  task automatic send_item(stim_row_t r);
    answer_t a;
    int gap;
    func <= r.fn;
    sample_id <= r.smp;
    metric_id <= r.met;
    gc_percent <= r.gc;
    value_hundredths <= r.val;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (histogram_step(r, a)) pending_answers.push_back(r.typed ? r.ans : a);
    // Insert a gap, mostly short, now and then long.
    gap = 0;
    if (idle_enable && $urandom_range(99) < 30)
      gap = ($urandom_range(99) < 90) ? $urandom_range(3, 1) : $urandom_range(60, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic stim_row_t row(logic [1:0] fn, int s, int m, int g, int v);
    row = '{fn: fn, smp: s[0:0], met: m[1:0], gc: g[6:0], val: v[15:0],
            typed: 1'b0, ans: '{med: '0, empty: 1'b0, win: '0}};
  endfunction

  function automatic stim_row_t row_exp(logic [1:0] fn, int s, int m, int g,
                                        int v, int med, bit emp, int win);
    row_exp = row(fn, s, m, g, v);
    row_exp.typed = 1'b1;
    row_exp.ans = '{med: med[8:0], empty: emp, win: win[19:0]};
  endfunction

  // Random item: mostly a small pool of groups so medians see real data.
  function automatic stim_row_t random_row();
    stim_row_t r;
    int pick;
    r = row(FUNC_RECORD, 0, 0, 0, 0);
    pick = $urandom_range(99);
    r.fn = (pick < 64) ? FUNC_RECORD : (pick < 84) ? FUNC_MEDIAN :
           (pick < 95) ? FUNC_COUNT : FUNC_UNUSED;
    if ($urandom_range(99) < 80) begin
      r.smp = 1'($urandom_range(1));
      r.met = 2'($urandom_range(1) * 3);
      r.gc  = ($urandom_range(1) == 0) ? 7'd0 : 7'd100;
      if ($urandom_range(3) == 0) r.gc = 7'($urandom_range(3, 1) * 25);
    end else begin
      r.smp = 1'($urandom_range(1));
      r.met = 2'($urandom_range(3));
      r.gc  = 7'($urandom_range(127));
    end
    pick = $urandom_range(99);
    r.val = (pick < 75) ? 16'($urandom_range(300)) :
            (pick < 85) ? 16'($urandom_range(40, 0) + 120) : 16'($urandom);
    return r;
  endfunction

  // Stimulus: directed table, then random traffic.
  initial begin
    stim_row_t dir_table[$];
    stim_row_t r;
    rst = 1'b1;
    in_valid = 1'b0;
    func = FUNC_RECORD;
    sample_id = '0;
    metric_id = '0;
    gc_percent = '0;
    value_hundredths = '0;
    idle_enable = 1'b1;
    hold_request = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Empty after reset, then clamping at both ends of the value range.
    dir_table.push_back(row_exp(FUNC_MEDIAN, 0, 0, 0, 0, 0, 1, 0));
    dir_table.push_back(row_exp(FUNC_COUNT, 1, 3, 0, 0, 0, 1, 0));
    dir_table.push_back(row(FUNC_RECORD, 0, 0, 0, -32768));
    dir_table.push_back(row(FUNC_RECORD, 0, 0, 0, 32767));
    dir_table.push_back(row_exp(FUNC_MEDIAN, 0, 0, 0, 0, 255, 0, 0));
    dir_table.push_back(row_exp(FUNC_COUNT, 1, 2, 0, -1, 0, 0, 2));
    // Odd count: one middle bin counted twice.
    dir_table.push_back(row(FUNC_RECORD, 1, 3, 100, 255));
    dir_table.push_back(row_exp(FUNC_MEDIAN, 1, 3, 100, 0, 510, 0, 0));
    dir_table.push_back(row(FUNC_RECORD, 1, 3, 100, 256));
    dir_table.push_back(row(FUNC_RECORD, 1, 3, 100, 100));
    dir_table.push_back(row_exp(FUNC_MEDIAN, 1, 3, 100, 0, 510, 0, 0));
    // Out-of-range GC level: record dropped, queries look empty.
    dir_table.push_back(row(FUNC_RECORD, 0, 0, 127, 50));
    dir_table.push_back(row(FUNC_RECORD, 0, 0, 101, 50));
    dir_table.push_back(row_exp(FUNC_MEDIAN, 0, 0, 127, 0, 0, 1, 0));
    dir_table.push_back(row_exp(FUNC_COUNT, 0, 0, 101, 0, 0, 1, 0));
    dir_table.push_back(row_exp(FUNC_COUNT, 0, 0, 127, 0, 0, 1, 0));
    // Unused function code: no answer, no state change.
    dir_table.push_back(row(FUNC_UNUSED, 0, 0, 0, 7));
    dir_table.push_back(row_exp(FUNC_COUNT, 0, 0, 0, 0, 0, 0, 2));
    dir_table.push_back(row(FUNC_RECORD, 1, 0, 0, 1));
    dir_table.push_back(row(FUNC_RECORD, 1, 0, 0, 3));
    dir_table.push_back(row(FUNC_MEDIAN, 1, 0, 0, 0));
    dir_table.push_back(row(FUNC_MEDIAN, 1, 3, 100, 0));
    dir_table.push_back(row_exp(FUNC_COUNT, 0, 3, 100, 0, 0, 1, 0));
    foreach (dir_table[i]) send_item(dir_table[i]);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      // Run a stretch with no idling on the sender or receiver side.
      idle_enable = !(n >= 600 && n < 800);
      // Ask the receiver for one long hold-off while we keep offering.
      if (n == 300) hold_request = 1'b1;
      r = random_row();
      send_item(r);
    end
    in_valid <= 1'b0;

    while (pending_answers.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (errors == 0)
      $display("binned_histogram_median_core test passed");
    else
      $display("binned_histogram_median_core test failed");
    $finish;
  end

  // Receiver: check each transfer, then pick the next stall value.
  initial begin
    answer_t want;
    int stall_left;
    int hold_left;
    out_stall = 1'b0;
    stall_left = 0;
    hold_left = 0;
    errors = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (pending_answers.size() == 0) begin
          $display("%0t: unexpected result med=%0d empty=%0d win=%0d",
                   $time, median_sum, is_empty, window_count);
          errors++;
        end else begin
          want = pending_answers.pop_front();
          if (median_sum !== want.med) begin
            $display("%0t: median_sum expected %0d actual %0d",
                     $time, want.med, median_sum);
            errors++;
          end
          if (is_empty !== want.empty) begin
            $display("%0t: is_empty expected %0d actual %0d",
                     $time, want.empty, is_empty);
            errors++;
          end
          if (window_count !== want.win) begin
            $display("%0t: window_count expected %0d actual %0d",
                     $time, want.win, window_count);
            errors++;
          end
        end
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = 3000;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (idle_enable && $urandom_range(99) < 25)
          stall_left = ($urandom_range(99) < 90) ? $urandom_range(3, 1)
                                                 : $urandom_range(60, 10);
      end
    end
  end

  // Watchdog on total run length.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("binned_histogram_median_core test failed");
        $finish;
      end
    end
  end

endmodule
